// ----- rtl/udec_pkg.sv -----
// shared types and constants of the utf-8 code point decoder
`default_nettype none

package udec_pkg;

    // width of a decoded code point
    localparam int unsigned CpWidth = 21;

    // replacement character for broken input
    localparam logic [CpWidth-1:0] QMARK = CpWidth'(63);

    // default depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // one command: a run of replacement marks, then an optional code point
    typedef struct packed {
        logic [2:0]         q_count;  // replacement marks to emit first
        logic               has_cp;   // a decoded code point follows the marks
        logic [CpWidth-1:0] cp;       // decoded code point
        logic               fin;      // last byte of the text
    } cmd_t;

    // read side of the command queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

`default_nettype wire

// ----- rtl/udec_front.sv -----
// front part: classifies each byte, tracks the open sequence, builds commands
`default_nettype none

module udec_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [7:0]    text_byte,
    input  wire logic          final_byte,
    input  wire logic          q_full,
    output logic               q_push,
    output udec_pkg::cmd_t     q_cmd
);
    import udec_pkg::*;

    logic [CpWidth-1:0] part_reg;
    logic [CpWidth-1:0] part_next;
    logic [1:0]         need_reg;
    logic [1:0]         need_next;
    logic [1:0]         held_reg;
    logic [1:0]         held_next;

    logic               accept;
    logic               is_cont;
    logic               is_ascii;
    logic               is_lead2;
    logic               is_lead3;
    logic               is_lead4;
    logic [2:0]         q_cnt;
    logic               has_cp;
    logic [CpWidth-1:0] cp;

    // byte classes
    assign is_cont  = (text_byte[7:6] == 2'b10);
    assign is_ascii = !text_byte[7];
    assign is_lead2 = (text_byte[7:5] == 3'b110);
    assign is_lead3 = (text_byte[7:4] == 4'b1110);
    assign is_lead4 = (text_byte[7:3] == 5'b11110);

    assign accept = push && !q_full;

    // next sequence state and the results this byte causes
    always_comb
    begin
        part_next = part_reg;
        need_next = need_reg;
        held_next = held_reg;
        q_cnt     = 3'd0;
        has_cp    = 1'b0;
        cp        = {{(CpWidth-8){1'b0}}, text_byte};

        if ((need_reg != 2'd0) && is_cont)
        begin
            part_next = {part_reg[CpWidth-7:0], text_byte[5:0]};
            need_next = need_reg - 2'd1;
            held_next = held_reg + 2'd1;
            if (need_reg == 2'd1)
            begin
                has_cp    = 1'b1;
                cp        = part_next;
                part_next = '0;
                held_next = 2'd0;
            end
        end
        else
        begin
            // broken sequence: flush lead and held continuations
            if (need_reg != 2'd0)
            begin
                q_cnt     = 3'd1 + {1'b0, held_reg};
                part_next = '0;
                need_next = 2'd0;
                held_next = 2'd0;
            end
            // decode the byte as a fresh one
            if (is_ascii)
            begin
                has_cp = 1'b1;
            end
            else if (is_lead2)
            begin
                part_next = {{(CpWidth-5){1'b0}}, text_byte[4:0]};
                need_next = 2'd1;
                held_next = 2'd0;
            end
            else if (is_lead3)
            begin
                part_next = {{(CpWidth-4){1'b0}}, text_byte[3:0]};
                need_next = 2'd2;
                held_next = 2'd0;
            end
            else if (is_lead4)
            begin
                part_next = {{(CpWidth-3){1'b0}}, text_byte[2:0]};
                need_next = 2'd3;
                held_next = 2'd0;
            end
            else
            begin
                q_cnt = q_cnt + 3'd1;
            end
        end

        // end of text: flush whatever is still open
        if (final_byte)
        begin
            if (need_next != 2'd0)
            begin
                q_cnt = q_cnt + 3'd1 + {1'b0, held_next};
            end
            part_next = '0;
            need_next = 2'd0;
            held_next = 2'd0;
        end
    end

    // command toward the queue, only when the byte yields results
    assign q_cmd.q_count = q_cnt;
    assign q_cmd.has_cp  = has_cp;
    assign q_cmd.cp      = cp;
    assign q_cmd.fin     = final_byte;
    assign q_push        = accept && ((q_cnt != 3'd0) || has_cp);

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= '0;
            need_reg <= 2'd0;
            held_reg <= 2'd0;
        end
        else if (accept)
        begin
            part_reg <= part_next;
            need_reg <= need_next;
            held_reg <= held_next;
        end
    end

    // no sequence open means nothing held
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (need_reg == 2'd0) |-> (held_reg == 2'd0 && part_reg == '0))
        else $error("front state not clean with no sequence open");

    // a sequence never exceeds four bytes
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, need_reg} + {1'b0, held_reg}) <= 3'd3)
        else $error("front sequence longer than four bytes");

endmodule

`default_nettype wire

// ----- rtl/udec_queue.sv -----
// short command queue between front and back
`default_nettype none

module udec_queue #(
    parameter int unsigned DEPTH = udec_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire udec_pkg::cmd_t  wr_cmd,
    output logic                 full,
    input  wire logic            rd_pop,
    output udec_pkg::cmd_head_t  head
);
    import udec_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
    localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
    localparam logic [CntW-1:0] CntOne  = CntW'(1);

    cmd_t            slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_wr;
    logic            do_rd;

    assign full       = (count_reg == CntFull);
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrOne;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrOne;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CntOne;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CntOne;
            end
        end
    end

    // fill count stays within the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntFull)
        else $error("queue count beyond depth");

    // the front never writes into a full queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

endmodule

`default_nettype wire

// ----- rtl/udec_back.sv -----
// back part: expands each command into result words behind an output register
`default_nettype none

module udec_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire udec_pkg::cmd_head_t  head,
    output logic                      head_pop,
    output logic [20:0]               code_point,
    output logic                      substituted,
    output logic                      text_end,
    output logic                      empty,
    input  wire logic                 pop
);
    import udec_pkg::*;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CpWidth-1:0] cp_reg;
    logic [CpWidth-1:0] cp_next;
    logic               sub_reg;
    logic               sub_next;
    logic               end_reg;
    logic               end_next;
    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;

    logic               load;
    logic [2:0]         total;
    logic               is_last;
    logic               is_mark;

    // position inside the current command
    assign load    = !out_valid_reg || pop;
    assign total   = head.cmd.q_count + {2'b00, head.cmd.has_cp};
    assign is_last = ((idx_reg + 3'd1) == total);
    assign is_mark = (idx_reg < head.cmd.q_count);

    // next result word
    always_comb
    begin
        out_valid_next = out_valid_reg;
        cp_next        = cp_reg;
        sub_next       = sub_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        head_pop       = 1'b0;
        if (load)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                cp_next  = is_mark ? QMARK : head.cmd.cp;
                sub_next = is_mark;
                end_next = head.cmd.fin && is_last;
                if (is_last)
                begin
                    head_pop = 1'b1;
                    idx_next = 3'd0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_next;
        sub_reg <= sub_next;
        end_reg <= end_next;
    end

    assign code_point  = cp_reg;
    assign substituted = sub_reg;
    assign text_end    = end_reg;
    assign empty       = !out_valid_reg;

    // the word index stays inside the command at the head
    a_idx_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (idx_reg < total))
        else $error("back index past end of command");

    // a substituted word always carries the replacement mark
    a_mark_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sub_reg) |-> (cp_reg == QMARK))
        else $error("substituted word without replacement mark");

endmodule

`default_nettype wire

// ----- rtl/utf8_codepoint_decoder.sv -----
// The first result word of a byte passes the command queue and then the output register.
// The front takes one byte per cycle while the queue is not full; the back part emits
// one word per cycle while the receiver pops, so a byte yielding n words holds it until all n are out.
// A queue of QUEUE_DEPTH commands lets the front keep taking bytes meanwhile.
// Reset (rst_n low, asynchronous) closes any open sequence and empties queue and output.
`default_nettype none

module utf8_codepoint_decoder #(
    parameter int unsigned QUEUE_DEPTH = udec_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    input  wire logic        final_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      code_point,
    output logic             substituted,
    output logic             text_end
);
    import udec_pkg::*;

    logic      q_push;
    cmd_t      q_cmd;
    logic      q_full;
    logic      head_pop;
    cmd_head_t head;

    assign full = q_full;

    // byte classification and sequence tracking
    udec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // command queue
    udec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (q_cmd),
        .full   (q_full),
        .rd_pop (head_pop),
        .head   (head)
    );

    // result word expansion
    udec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_pop    (head_pop),
        .code_point  (code_point),
        .substituted (substituted),
        .text_end    (text_end),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

`default_nettype wire

// ----- tb/utf8_codepoint_decoder_test.sv -----
// self-checking testbench for the utf-8 code point decoder
`timescale 1ns / 1ps

module utf8_codepoint_decoder_test;

    import udec_pkg::*;

    // cycles with no word moving on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT = 2000;
    // cycles allowed after the last expected word for anything extra to show up
    localparam int unsigned TAIL_CYCLES = 16;
    // bytes of random text per idling phase, at least
    localparam int unsigned PHASE_BYTES = 40;
    localparam int unsigned NUM_PHASES = 4;

    // one expected output word
    typedef struct {
        logic [CpWidth-1:0] cp;
        logic               sub;
        logic               last;
    } cp_word_t;

    // kinds of character the random text generator builds
    typedef enum int unsigned {
        CH_ASCII,
        CH_TWO,
        CH_THREE,
        CH_FOUR,
        CH_CUT,
        CH_STRAY,
        CH_BADLEAD,
        CH_NOISE
    } char_kind_e;

    // decoder model plus the queue of code points still owed by the block
    class cp_scoreboard;
        localparam int unsigned MAX_WORDS = 4;
        localparam int unsigned PRINT_CAP = 40;

        cp_word_t           owed_q[$];
        logic [CpWidth-1:0] acc;
        logic [1:0]         need;
        logic [1:0]         held;
        cp_word_t           step_w[MAX_WORDS];
        int unsigned        step_n;
        int unsigned        errors;
        int unsigned        words;
        int unsigned        subs;

        function new();
            acc = '0;
            need = '0;
            held = '0;
            step_n = 0;
            errors = 0;
            words = 0;
            subs = 0;
        endfunction

        function int unsigned outstanding();
            return owed_q.size();
        endfunction

        // collect one word of the current byte, dropping beyond the limit
        function void put(logic [CpWidth-1:0] cp, logic sub);
            if (step_n < MAX_WORDS)
            begin
                step_w[step_n].cp = cp;
                step_w[step_n].sub = sub;
                step_w[step_n].last = 1'b0;
                step_n++;
            end
        endfunction

        // abandon the open sequence: one mark for the lead and each continuation
        function void close_open();
            int unsigned count;
            count = 1 + held;
            for (int unsigned k = 0; k < count; k++)
                put(QMARK, 1'b1);
            acc = '0;
            need = '0;
            held = '0;
        endfunction

        // treat a byte as the start of a new character
        function void start_fresh(logic [7:0] b);
            if (!b[7])
                put(CpWidth'(b), 1'b0);
            else if (b[7:5] == 3'b110)
            begin
                acc = CpWidth'(b[4:0]);
                need = 2'd1;
                held = '0;
            end
            else if (b[7:4] == 4'b1110)
            begin
                acc = CpWidth'(b[3:0]);
                need = 2'd2;
                held = '0;
            end
            else if (b[7:3] == 5'b11110)
            begin
                acc = CpWidth'(b[2:0]);
                need = 2'd3;
                held = '0;
            end
            else
                put(QMARK, 1'b1);
        endfunction

        // accepted byte: work out the words it causes
        function void note_byte(logic [7:0] b, logic fin);
            step_n = 0;
            if (need != 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    acc = {acc[CpWidth-7:0], b[5:0]};
                    need = need - 2'd1;
                    held = held + 2'd1;
                    if (need == 0)
                    begin
                        put(acc, 1'b0);
                        acc = '0;
                        held = '0;
                    end
                end
                else
                begin
                    close_open();
                    start_fresh(b);
                end
            end
            else
                start_fresh(b);

            // end of text flushes whatever is still open
            if (fin)
            begin
                if (need != 0)
                    close_open();
                acc = '0;
                held = '0;
                if (step_n > 0)
                    step_w[step_n-1].last = 1'b1;
            end
            for (int unsigned i = 0; i < step_n; i++)
                owed_q.push_back(step_w[i]);
        endfunction

        task report_mismatch(string what);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // popped word against the oldest owed one
        task check_word(logic [CpWidth-1:0] cp, logic sub, logic last);
            cp_word_t w;
            words++;
            if (sub)
                subs++;
            if (owed_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word cp=%0h sub=%0b end=%0b",
                                          cp, sub, last));
                return;
            end
            w = owed_q.pop_front();
            if (cp !== w.cp)
                report_mismatch($sformatf("code_point %0h, want %0h", cp, w.cp));
            if (sub !== w.sub)
                report_mismatch($sformatf("substituted %0b, want %0b", sub, w.sub));
            if (last !== w.last)
                report_mismatch($sformatf("text_end %0b, want %0b", last, w.last));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         text_byte;
    logic               final_byte;
    logic               empty;
    logic               pop;
    logic [CpWidth-1:0] code_point;
    logic               substituted;
    logic               text_end;

    cp_scoreboard       sb;
    logic [7:0]         text_q[$];
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    int unsigned        bytes_sent;
    int unsigned        texts_sent;
    int unsigned        quiet_cycles;

    // directed bytes, final flag in bit 8
    localparam logic [8:0] DIRECTED [24] = '{
        9'h000, 9'h07F,                       // ascii extremes
        9'h0C2, 9'h0A9,                       // two bytes
        9'h0E2, 9'h082, 9'h0AC,               // three bytes
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,       // four bytes, largest value
        9'h0C0, 9'h080,                       // overlong form passes
        9'h080,                               // stray continuation
        9'h0FF,                               // invalid lead
        9'h0E2, 9'h082, 9'h041,               // broken by ascii
        9'h0F0, 9'h09F, 9'h098, 9'h1F0,       // broken by a final lead: four marks
        9'h1F4,                               // lone lead as the last byte
        9'h1C3                                // lead flushed at the end
    };

    utf8_codepoint_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .final_byte  (final_byte),
        .empty       (empty),
        .pop         (pop),
        .code_point  (code_point),
        .substituted (substituted),
        .text_end    (text_end)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: pop with random stalls
    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_stall_pct);

    // check every word taken
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_word(code_point, substituted, text_end);
    end

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d still owed",
                     STALL_LIMIT, sb.outstanding());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one byte, idling first at random, and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        text_byte <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (full);
        sb.note_byte(b, fin);
        bytes_sent++;
    endtask

    // hold the sender until every owed word has been popped
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    // lead byte of a sequence of len bytes, any payload bits
    function automatic logic [7:0] lead_byte(int unsigned len);
        case (len)
            2: return {3'b110, 5'($urandom_range(31))};
            3: return {4'b1110, 4'($urandom_range(15))};
            default: return {5'b11110, 3'($urandom_range(7))};
        endcase
    endfunction

    // append one random character, mostly well formed
    function automatic void add_char();
        char_kind_e  kind;
        int unsigned r;
        int unsigned len;
        r = $urandom_range(99);
        if (r < 26)
            kind = CH_ASCII;
        else if (r < 42)
            kind = CH_TWO;
        else if (r < 58)
            kind = CH_THREE;
        else if (r < 72)
            kind = CH_FOUR;
        else if (r < 81)
            kind = CH_CUT;
        else if (r < 87)
            kind = CH_STRAY;
        else if (r < 93)
            kind = CH_BADLEAD;
        else
            kind = CH_NOISE;

        case (kind)
            CH_ASCII:   text_q.push_back(8'($urandom_range(127)));
            CH_STRAY:   text_q.push_back(cont_byte());
            CH_BADLEAD: text_q.push_back(8'($urandom_range(255, 248)));
            CH_NOISE:   text_q.push_back(8'($urandom_range(255)));
            CH_CUT:
            begin
                // lead with too few continuations behind it
                len = $urandom_range(4, 2);
                text_q.push_back(lead_byte(len));
                repeat ($urandom_range(len - 2)) text_q.push_back(cont_byte());
            end
            default:
            begin
                len = (kind == CH_TWO) ? 2 : (kind == CH_THREE) ? 3 : 4;
                text_q.push_back(lead_byte(len));
                repeat (len - 1) text_q.push_back(cont_byte());
            end
        endcase
    endfunction

    // one random text, usually closed by a final byte
    task automatic send_text();
        logic closed;
        text_q.delete();
        repeat ($urandom_range(8, 1)) add_char();
        closed = ($urandom_range(99) < 85);
        foreach (text_q[i])
            send_byte(text_q[i], closed && (i == text_q.size() - 1));
        if (closed)
            texts_sent++;
    endtask

    // main sequence
    initial
    begin
        int unsigned phase_start;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        text_byte = '0;
        final_byte = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        texts_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed bytes at full rate
        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
            if (DIRECTED[i][8])
                texts_sent++;
        end
        drain();

        // random text under each idling pattern
        for (int unsigned phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_text();
            drain();
        end

        // let anything extra surface
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d bytes in %0d closed texts under four idling patterns;",
                 bytes_sent, texts_sent);
        $display("checked %0d words, %0d of them replacement marks, %0d mismatches.",
                 sb.words, sb.subs, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
